FILE: rtl/core/vas_pkg.sv
// ============================================================================
// vas_pkg
// Shared types for the voice allocator: request codes, controller states,
// and the command and status groups between controller and datapath.
// ============================================================================
package vas_pkg;

    // Request codes carried on the mode field.
    typedef enum logic [1:0] {
        MODE_FIND    = 2'd0,
        MODE_KEY_ON  = 2'd1,
        MODE_KEY_OFF = 2'd2,
        MODE_POLL    = 2'd3
    } t_mode;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SCAN,
        ST_COMPACT,
        ST_APPEND,
        ST_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;          // capture the request beat
        logic take_free;     // answer a find with the lowest free voice
        logic apply;         // latch the removal mask and update masks
        logic scan_step;     // test one list entry for stealing
        logic compact_step;  // move one list entry during removal
        logic append;        // key on: set the voice and add it at the tail
        logic publish;       // move the result into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_find;
        logic free_any;
        logic list_empty;
        logic kill_any;
        logic append_req;
        logic scan_hit;
        logic rd_last;
        logic out_free;
    } t_status;

endpackage

FILE: rtl/core/vas_ctrl.sv
// ============================================================================
// vas_ctrl
// Controller for the voice allocator. Sequences one request at a time
// through decode, list scan or list compaction, append and result hand-off.
// ============================================================================
module vas_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  vas_pkg::t_status i_status,
    output vas_pkg::t_cmd    o_cmd
);
    import vas_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (i_status.is_find) begin
                    if (i_status.free_any || i_status.list_empty) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end else if (i_status.kill_any) begin
                    n_state = ST_COMPACT;
                end else if (i_status.append_req) begin
                    n_state = ST_APPEND;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_SCAN: begin
                if (i_status.scan_hit || i_status.rd_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_COMPACT: begin
                if (i_status.rd_last) begin
                    n_state = i_status.append_req ? ST_APPEND : ST_DONE;
                end
            end
            ST_APPEND: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Output decode.
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_DECIDE: begin
                o_cmd.take_free = i_status.is_find && i_status.free_any;
                o_cmd.apply     = !i_status.is_find;
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
            end
            ST_COMPACT: begin
                o_cmd.compact_step = 1'b1;
            end
            ST_APPEND: begin
                o_cmd.append = 1'b1;
            end
            ST_DONE: begin
                o_cmd.publish = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

FILE: rtl/core/vas_datapath.sv
// ============================================================================
// vas_datapath
// Datapath for the voice allocator: active mask, last status word, the
// allocation-ordered list of voices and priorities, scan and compaction
// pointers, the working result and the output register.
// ============================================================================
module vas_datapath #(
    parameter int VOICES = 24
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [1:0]       i_mode,
    input  logic [4:0]       i_voice_number,
    input  logic [7:0]       i_priority_req,
    input  logic [23:0]      i_status_bits,
    input  vas_pkg::t_cmd    i_cmd,
    output vas_pkg::t_status o_status,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output logic             o_found,
    output logic [4:0]       o_chosen_voice,
    output logic [23:0]      o_released_mask,
    output logic [23:0]      o_active_mask
);
    import vas_pkg::*;

    localparam int IW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int CW = $clog2(VOICES + 1);

    // Captured request.
    t_mode              r_mode;
    logic [4:0]         r_voice;
    logic [7:0]         r_prio;
    logic [23:0]        r_status;

    // Allocator state.
    logic [VOICES-1:0]  r_active;
    logic [23:0]        r_prev_status;
    logic [4:0]         r_ord_voice [VOICES];
    logic [7:0]         r_ord_prio  [VOICES];
    logic [CW-1:0]      r_count;

    // Walk pointers and removal mask.
    logic [CW-1:0]      r_rd;
    logic [CW-1:0]      r_wr;
    logic [VOICES-1:0]  r_kill;

    // Working result.
    logic               r_found;
    logic [4:0]         r_chosen;
    logic [23:0]        r_released;

    // Output register.
    logic               r_out_valid;
    logic               r_out_found;
    logic [4:0]         r_out_chosen;
    logic [23:0]        r_out_released;
    logic [23:0]        r_out_active;

    logic [VOICES-1:0]  w_voice_bit;
    logic [VOICES-1:0]  w_status_v;
    logic [VOICES-1:0]  w_prev_v;
    logic [VOICES-1:0]  w_kill;
    logic [31:0]        w_status_ext;
    logic [31:0]        w_prev_ext;
    logic [31:0]        w_kill_ext;
    logic [31:0]        w_newkill_ext;
    logic [31:0]        w_active_ext;
    logic [4:0]         w_free_idx;
    logic               w_free_any;
    logic [4:0]         w_rd_voice;
    logic [7:0]         w_rd_prio;
    logic [CW-1:0]      w_rd_inc;
    logic [CW-1:0]      w_wr_inc;
    logic               w_keep;
    logic               w_changed;

    // One-hot of the requested voice; zero when the number is out of range.
    always_comb begin
        for (int i = 0; i < VOICES; i++) begin
            w_voice_bit[i] = (r_voice == 5'(i));
        end
    end

    // Status words widened to the voice count.
    assign w_status_ext = {8'b0, r_status};
    assign w_prev_ext   = {8'b0, r_prev_status};
    assign w_status_v   = w_status_ext[VOICES-1:0];
    assign w_prev_v     = w_prev_ext[VOICES-1:0];
    assign w_changed    = (r_status != r_prev_status);

    // Voices that this request removes from the list.
    always_comb begin
        case (r_mode)
            MODE_KEY_ON, MODE_KEY_OFF: w_kill = w_voice_bit & r_active;
            MODE_POLL: w_kill = w_changed ? (w_status_v & ~w_prev_v & r_active) : '0;
            default:   w_kill = '0;
        endcase
    end

    assign w_kill_ext    = 32'(r_kill);
    assign w_newkill_ext = 32'(w_kill);
    assign w_active_ext  = 32'(r_active);

    // Lowest free voice.
    always_comb begin
        w_free_idx = '0;
        for (int i = VOICES - 1; i >= 0; i--) begin
            if (!r_active[i]) begin
                w_free_idx = 5'(i);
            end
        end
    end
    assign w_free_any = ~&r_active;

    // List entry under the read pointer.
    assign w_rd_voice = r_ord_voice[r_rd[IW-1:0]];
    assign w_rd_prio  = r_ord_prio[r_rd[IW-1:0]];
    assign w_rd_inc   = r_rd + CW'(1);
    assign w_wr_inc   = r_wr + CW'(1);
    assign w_keep     = !w_kill_ext[w_rd_voice];

    // Status to the controller.
    always_comb begin
        o_status.is_find    = (r_mode == MODE_FIND);
        o_status.free_any   = w_free_any;
        o_status.list_empty = (r_count == '0);
        o_status.kill_any   = |w_kill;
        o_status.append_req = (r_mode == MODE_KEY_ON) && (|w_voice_bit);
        o_status.scan_hit   = (w_rd_prio < r_prio);
        o_status.rd_last    = (w_rd_inc == r_count);
        o_status.out_free   = !r_out_valid || i_out_ready;
    end

    // Control registers: masks, list fill count and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active      <= '0;
            r_prev_status <= '1;
            r_count       <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cmd.apply) begin
                r_active <= r_active & ~w_kill;
                if (r_mode == MODE_POLL) begin
                    r_prev_status <= r_status;
                end
            end
            if (i_cmd.compact_step && o_status.rd_last) begin
                r_count <= w_keep ? w_wr_inc : r_wr;
            end
            if (i_cmd.append) begin
                r_active <= r_active | w_voice_bit;
                if (r_count < CW'(VOICES)) begin
                    r_count <= r_count + CW'(1);
                end
            end
            if (i_cmd.publish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request capture, pointers, working result and output payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode     <= t_mode'(i_mode);
            r_voice    <= i_voice_number;
            r_prio     <= i_priority_req;
            r_status   <= i_status_bits;
            r_rd       <= '0;
            r_wr       <= '0;
            r_found    <= 1'b0;
            r_chosen   <= '0;
            r_released <= '0;
        end
        if (i_cmd.take_free) begin
            r_found  <= 1'b1;
            r_chosen <= w_free_idx;
        end
        if (i_cmd.apply) begin
            r_kill <= w_kill;
            if (r_mode == MODE_POLL) begin
                r_released <= w_newkill_ext[23:0];
            end
        end
        if (i_cmd.scan_step) begin
            r_rd <= w_rd_inc;
            if (o_status.scan_hit) begin
                r_found  <= 1'b1;
                r_chosen <= w_rd_voice;
            end
        end
        if (i_cmd.compact_step) begin
            r_rd <= w_rd_inc;
            if (w_keep) begin
                r_wr <= w_wr_inc;
            end
        end
        if (i_cmd.publish) begin
            r_out_found    <= r_found;
            r_out_chosen   <= r_chosen;
            r_out_released <= r_released;
            r_out_active   <= w_active_ext[23:0];
        end
    end

    // Ordered list storage: compaction moves entries down, key on appends.
    always_ff @(posedge i_clk) begin
        if (i_cmd.compact_step && w_keep) begin
            r_ord_voice[r_wr[IW-1:0]] <= w_rd_voice;
            r_ord_prio[r_wr[IW-1:0]]  <= w_rd_prio;
        end
        if (i_cmd.append && (r_count < CW'(VOICES))) begin
            r_ord_voice[r_count[IW-1:0]] <= r_voice;
            r_ord_prio[r_count[IW-1:0]]  <= r_prio;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_found         = r_out_found;
    assign o_chosen_voice  = r_out_chosen;
    assign o_released_mask = r_out_released;
    assign o_active_mask   = r_out_active;

    // The list never holds more entries than there are voices.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(VOICES))
        else $error("list fill count exceeds voice count");

    // Compaction never writes ahead of the entry it reads.
    a_wr_behind_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.compact_step |-> (r_wr <= r_rd))
        else $error("compaction write pointer passed read pointer");

    // A result without a voice carries voice zero.
    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.publish && !r_found |=> (r_out_chosen == '0))
        else $error("not-found result carries a nonzero voice");

    // A steal hit is reported as found in the next cycle.
    a_hit_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan_step && o_status.scan_hit |=> r_found)
        else $error("steal hit was not recorded");

endmodule

FILE: rtl/core/voice_allocator_with_stealing.sv
// ============================================================================
// voice_allocator_with_stealing
// Voice allocator with oldest-first stealing by priority. Finds a free
// voice, keeps the allocation order of active voices, and releases voices
// on key off or on newly risen status bits.
// ============================================================================
//
//  Channel   Signals                                        Direction
//  -------   --------------------------------------------   ---------
//  request   i_in_valid / o_in_ready, i_mode, i_voice_number,   in
//            i_priority_req, i_status_bits
//  result    o_out_valid / i_out_ready, o_found,                out
//            o_chosen_voice, o_released_mask, o_active_mask
//
//  One request beat is handled at a time. A find with a free voice takes
//  the lowest free one; otherwise it walks the list from the oldest entry
//  for a steal. Key on, key off and poll walk the list to compact it when
//  a voice leaves it, and a key on for a voice in range appends it at the tail.
//  The list walk moves one list entry per cycle.
//  After reset the block is ready at once. A stalled result stays in the
//  output register while the next request beat is already taken and worked.
//
module voice_allocator_with_stealing #(
    parameter int VOICES = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_mode,
    input  logic [4:0]  i_voice_number,
    input  logic [7:0]  i_priority_req,
    input  logic [23:0] i_status_bits,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_found,
    output logic [4:0]  o_chosen_voice,
    output logic [23:0] o_released_mask,
    output logic [23:0] o_active_mask
);
    import vas_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    // Sequencing of one request.
    vas_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Allocator state, list and result registers.
    vas_datapath #(
        .VOICES (VOICES)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_mode          (i_mode),
        .i_voice_number  (i_voice_number),
        .i_priority_req  (i_priority_req),
        .i_status_bits   (i_status_bits),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_found         (o_found),
        .o_chosen_voice  (o_chosen_voice),
        .o_released_mask (o_released_mask),
        .o_active_mask   (o_active_mask)
    );

endmodule
